/* sv/ils_pkg.sv */
package ils_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ACT_APPEND      = 3'd0,
		ACT_INSERT      = 3'd1,
		ACT_GET         = 3'd2,
		ACT_SET         = 3'd3,
		ACT_REMOVE_AT   = 3'd4,
		ACT_REMOVE_LAST = 3'd5,
		ACT_CLEAR       = 3'd6
	} act_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_WRV   = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

endpackage

/* sv/ils_ram.sv */
module ils_ram #(
	parameter int unsigned DEPTH = ils_pkg::DEPTH_DEF,
	parameter int unsigned WIDTH = ils_pkg::WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/indexed_list_store.sv */
// Fixed-capacity ordered list of WIDTH-bit words held in a DEPTH-entry RAM with one write
// and one registered read port. One transfer in gives one result transfer out. Append,
// get, set, remove-last, clear, insert at the tail and any failed request go straight to
// the response state. Insert before the tail shifts entries p..n-1 up a slot, then writes
// the new value at p; remove-at shifts entries p+1..n-1 down a slot. Entries move one slot
// per cycle through the RAM. A new request is taken while an earlier result waits.
module indexed_list_store #(
	parameter int unsigned DEPTH = ils_pkg::DEPTH_DEF,
	parameter int unsigned WIDTH = ils_pkg::WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 action,
	input  logic [$clog2(DEPTH+1)-1:0] position,
	input  logic [WIDTH-1:0]           item_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       ok,
	output logic [WIDTH-1:0]           read_value,
	output logic [$clog2(DEPTH+1)-1:0] live_count
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH+1);

	ils_pkg::state_t state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [AW-1:0]    ptr_q, ptr_d;
	logic [AW-1:0]    end_q, end_d;
	logic             up_q, up_d;
	logic [WIDTH-1:0] val_q, val_d;
	logic             res_ok_q, res_ok_d;
	logic             res_get_q, res_get_d;

	logic             out_valid_q;
	logic             ok_q;
	logic [WIDTH-1:0] read_value_q;
	logic [CW-1:0]    live_count_q;

	logic             we, re;
	logic [AW-1:0]    waddr, raddr;
	logic [WIDTH-1:0] wdata, rdata;

	logic [CW-1:0]    cnt_m1, pos_p1;
	logic             full, in_rng, resp_load;

	ils_ram #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cnt_m1    = cnt_q - 1'b1;
	assign pos_p1    = position + 1'b1;
	assign full      = (cnt_q == CW'(DEPTH));
	assign in_rng    = (position < cnt_q);
	assign in_ready  = (state_q == ils_pkg::S_IDLE);
	assign resp_load = (state_q == ils_pkg::S_RESP) && (!out_valid_q || out_ready);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ptr_d     = ptr_q;
		end_d     = end_q;
		up_d      = up_q;
		val_d     = val_q;
		res_ok_d  = res_ok_q;
		res_get_d = res_get_q;
		we        = 1'b0;
		waddr     = '0;
		wdata     = '0;
		re        = 1'b0;
		raddr     = '0;
		unique case (state_q)
			ils_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d   = ils_pkg::S_RESP;
					res_ok_d  = 1'b0;
					res_get_d = 1'b0;
					case (ils_pkg::act_t'(action))
						ils_pkg::ACT_APPEND: begin
							if (!full) begin
								we       = 1'b1;
								waddr    = cnt_q[AW-1:0];
								wdata    = item_value;
								cnt_d    = cnt_q + 1'b1;
								res_ok_d = 1'b1;
							end
						end
						ils_pkg::ACT_INSERT: begin
							if (position <= cnt_q && !full) begin
								cnt_d    = cnt_q + 1'b1;
								res_ok_d = 1'b1;
								if (position == cnt_q) begin
									we    = 1'b1;
									waddr = cnt_q[AW-1:0];
									wdata = item_value;
								end else begin
									re      = 1'b1;
									raddr   = cnt_m1[AW-1:0];
									ptr_d   = cnt_m1[AW-1:0];
									end_d   = position[AW-1:0];
									up_d    = 1'b1;
									val_d   = item_value;
									state_d = ils_pkg::S_SHIFT;
								end
							end
						end
						ils_pkg::ACT_GET: begin
							if (in_rng) begin
								re        = 1'b1;
								raddr     = position[AW-1:0];
								res_ok_d  = 1'b1;
								res_get_d = 1'b1;
							end
						end
						ils_pkg::ACT_SET: begin
							if (in_rng) begin
								we       = 1'b1;
								waddr    = position[AW-1:0];
								wdata    = item_value;
								res_ok_d = 1'b1;
							end
						end
						ils_pkg::ACT_REMOVE_AT: begin
							if (in_rng) begin
								cnt_d    = cnt_m1;
								res_ok_d = 1'b1;
								if (position != cnt_m1) begin
									re      = 1'b1;
									raddr   = pos_p1[AW-1:0];
									ptr_d   = pos_p1[AW-1:0];
									end_d   = cnt_m1[AW-1:0];
									up_d    = 1'b0;
									state_d = ils_pkg::S_SHIFT;
								end
							end
						end
						ils_pkg::ACT_REMOVE_LAST: begin
							if (cnt_q != '0) begin
								cnt_d    = cnt_m1;
								res_ok_d = 1'b1;
							end
						end
						ils_pkg::ACT_CLEAR: begin
							cnt_d    = '0;
							res_ok_d = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ils_pkg::S_SHIFT: begin
				// rdata holds slot ptr_q; move it one slot toward the gap
				we    = 1'b1;
				waddr = up_q ? ptr_q + 1'b1 : ptr_q - 1'b1;
				wdata = rdata;
				if (ptr_q == end_q) begin
					state_d = up_q ? ils_pkg::S_WRV : ils_pkg::S_RESP;
				end else begin
					re    = 1'b1;
					raddr = up_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
					ptr_d = raddr;
				end
			end
			ils_pkg::S_WRV: begin
				we      = 1'b1;
				waddr   = end_q;
				wdata   = val_q;
				state_d = ils_pkg::S_RESP;
			end
			ils_pkg::S_RESP: begin
				if (resp_load) begin
					state_d = ils_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ils_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ils_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q     <= ptr_d;
		end_q     <= end_d;
		up_q      <= up_d;
		val_q     <= val_d;
		res_ok_q  <= res_ok_d;
		res_get_q <= res_get_d;
		if (resp_load) begin
			ok_q         <= res_ok_q;
			read_value_q <= res_get_q ? rdata : '0;
			live_count_q <= cnt_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign read_value = read_value_q;
	assign live_count = live_count_q;

endmodule
